>>> design/sqsh_pkg.sv
// ----------------------------------------------------------------------------
// sqsh_pkg
// Shared types, constants and helpers for the song query signature hash unit.
// ----------------------------------------------------------------------------
package sqsh_pkg;

	localparam int WordW = 32;
	localparam int ByteW = 8;

	// id byte masks
	localparam logic [WordW-1:0] ByteMask0 = 32'h0000_00FF;
	localparam logic [WordW-1:0] ByteMask1 = 32'h0000_FF00;
	localparam logic [WordW-1:0] ByteMask2 = 32'h00FF_0000;
	localparam logic [WordW-1:0] ByteMask3 = 32'hFF00_0000;

	// shift amounts of the constant multipliers (x9, x17, x33)
	localparam int Shift9  = 3;
	localparam int Shift17 = 4;
	localparam int Shift33 = 5;

	// item codes
	localparam logic ModeByte   = 1'b0;
	localparam logic ModeFinish = 1'b1;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTE_MUL,
		ST_BYTE_ACC,
		ST_FIN_SUM,
		ST_FIN_MUL1,
		ST_FIN_MUL2,
		ST_FIN_OUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_SEL_BYTE,
		MUL_SEL_FIN1,
		MUL_SEL_FIN2
	} mul_sel_t;

	// sequencer controls to the datapath
	typedef struct packed {
		logic     in_ready;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     byte_acc;
		logic     fin_sum;
		logic     fin_load;
	} ctrl_t;

	// build the scrambled word from the id bytes
	function automatic word_t scramble_id(input word_t id);
		logic [ByteW-1:0] b0, b1, b2, b3, x2, x3;
		b0 = id[7:0];
		b1 = id[15:8];
		b2 = id[23:16];
		b3 = id[31:24];
		x2 = (b2 == '0) ? ~b1 : b2;
		x3 = (b3 == '0) ? ~b0 : b3;
		return {b0, x2, b1, x3};
	endfunction

endpackage

>>> design/sqsh_in_if.sv
// ----------------------------------------------------------------------------
// sqsh_in_if
// Input channel: one string byte or one finish word with the song id.
// ----------------------------------------------------------------------------
interface sqsh_in_if;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [7:0]        data_byte;
	logic signed [31:0] song_id;

	modport source (output valid, output mode, output data_byte, output song_id,
		input ready);
	modport sink (input valid, input mode, input data_byte, input song_id,
		output ready);
endinterface

>>> design/sqsh_out_if.sv
// ----------------------------------------------------------------------------
// sqsh_out_if
// Output channel: one signature word per finish item.
// ----------------------------------------------------------------------------
interface sqsh_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] signature;

	modport source (output valid, output signature, input ready);
	modport sink (input valid, input signature, output ready);
endinterface

>>> design/song_query_signature_hash_unit.sv
// Byte item: from accept until the next item can be taken, the steps are
// accept, multiply of byte by running weight, accumulate.
// Finish item: accept, sum, two passes through the shared multiplier and
// output load, which waits while the output register is still full.
// The single 32x32 multiplier is shared by both. Reset (arst_n low) returns
// both hashes to zero, the running weight to one and the sequencer to idle.
// ----------------------------------------------------------------------------
// song_query_signature_hash_unit
// Forward hash and weighted sum over string bytes, signature on finish.
// ----------------------------------------------------------------------------
module song_query_signature_hash_unit (
	input  logic clk,
	input  logic arst_n,
	sqsh_in_if.sink    req,
	sqsh_out_if.source rsp
);
	import sqsh_pkg::*;

	ctrl_t ctrl;
	logic  accept;
	logic  out_free;

	word_t fwd_q, wsum_q, weight_q;
	logic  odd_q;
	logic [ByteW-1:0] c_q;
	word_t id_q, t_q, s_q;
	word_t mul_a, mul_b, mul_prod;
	word_t c_ext;

	logic  out_valid_q;
	word_t sig_q;

	assign accept   = req.valid && ctrl.in_ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = ctrl.in_ready;

	sqsh_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_mode  (req.mode),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// select multiplier operands
	assign c_ext = {{(WordW-ByteW){c_q[ByteW-1]}}, c_q};

	always_comb begin
		unique case (ctrl.mul_sel)
			MUL_SEL_BYTE: begin
				mul_a = c_ext;
				mul_b = weight_q;
			end
			MUL_SEL_FIN1: begin
				mul_a = s_q;
				mul_b = fwd_q | t_q;
			end
			MUL_SEL_FIN2: begin
				mul_a = mul_prod;
				mul_b = wsum_q ^ id_q;
			end
			default: begin
				mul_a = c_ext;
				mul_b = weight_q;
			end
		endcase
	end

	sqsh_mul u_mul (
		.clk  (clk),
		.en   (ctrl.mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_prod)
	);

	// hash state: forward hash on accept, weighted sum on accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q    <= '0;
			wsum_q   <= '0;
			weight_q <= word_t'(1);
			odd_q    <= 1'b0;
		end else if (ctrl.fin_load) begin
			fwd_q    <= '0;
			wsum_q   <= '0;
			weight_q <= word_t'(1);
			odd_q    <= 1'b0;
		end else begin
			if (accept && req.mode == ModeByte) begin
				fwd_q <= (odd_q ? (fwd_q << Shift17) : (fwd_q << Shift9)) + fwd_q
					+ {{(WordW-ByteW){req.data_byte[ByteW-1]}}, req.data_byte};
			end
			if (ctrl.byte_acc) begin
				wsum_q   <= wsum_q + mul_prod;
				weight_q <= (odd_q ? (weight_q << Shift33) : (weight_q << Shift17))
					+ weight_q;
				odd_q    <= !odd_q;
			end
		end
	end

	// capture item payload and the finish sum
	always_ff @(posedge clk) begin
		if (accept) begin
			c_q  <= req.data_byte;
			id_q <= word_t'(req.song_id);
			t_q  <= scramble_id(word_t'(req.song_id));
		end
		if (ctrl.fin_sum) begin
			s_q <= (t_q ^ wsum_q) + (fwd_q | id_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fin_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin_load) begin
			sig_q <= mul_prod;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.signature = sig_q;

endmodule

>>> design/sqsh_mul.sv
// ----------------------------------------------------------------------------
// sqsh_mul
// Shared 32x32 multiplier, low word of the product registered.
// ----------------------------------------------------------------------------
module sqsh_mul (
	input  logic             clk,
	input  logic             en,
	input  sqsh_pkg::word_t  op_a,
	input  sqsh_pkg::word_t  op_b,
	output sqsh_pkg::word_t  prod
);
	import sqsh_pkg::*;

	word_t prod_lo;
	word_t prod_q;

	// multiply, keep the low word of the product
	assign prod_lo = op_a * op_b;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod_lo;
		end
	end

	assign prod = prod_q;

endmodule

>>> design/sqsh_fsm.sv
// ----------------------------------------------------------------------------
// sqsh_fsm
// Sequencer that steps the shared multiplier through byte and finish work.
// ----------------------------------------------------------------------------
module sqsh_fsm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_mode,
	input  logic            out_free,
	output sqsh_pkg::ctrl_t ctrl
);
	import sqsh_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_mode == ModeFinish) ? ST_FIN_SUM : ST_BYTE_MUL;
				end
			end
			ST_BYTE_MUL: state_d = ST_BYTE_ACC;
			ST_BYTE_ACC: state_d = ST_IDLE;
			ST_FIN_SUM:  state_d = ST_FIN_MUL1;
			ST_FIN_MUL1: state_d = ST_FIN_MUL2;
			ST_FIN_MUL2: state_d = ST_FIN_OUT;
			ST_FIN_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = MUL_SEL_BYTE;
		unique case (state_q)
			ST_IDLE:     ctrl.in_ready = 1'b1;
			ST_BYTE_MUL: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_SEL_BYTE;
			end
			ST_BYTE_ACC: ctrl.byte_acc = 1'b1;
			ST_FIN_SUM:  ctrl.fin_sum = 1'b1;
			ST_FIN_MUL1: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_SEL_FIN1;
			end
			ST_FIN_MUL2: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_SEL_FIN2;
			end
			ST_FIN_OUT:  ctrl.fin_load = out_free;
			default:     ctrl = '0;
		endcase
	end

endmodule
